// File: rtl/mwf_pkg.sv
// ----------------------------------------------------------------------------
// mwf_pkg
// Shared constants and types for the motionless window finder.
// ----------------------------------------------------------------------------
`default_nettype none

package mwf_pkg;

  // Frames at the start of a track that the search covers.
  localparam int unsigned SEARCH_FRAMES = 150;
  // Width of one coordinate sample, two's complement millimetres.
  localparam int unsigned SAMPLE_BITS   = 16;

  // Counters, window length and result fields.
  localparam int unsigned COUNT_W = 8;
  // Accumulated window cost, saturating.
  localparam int unsigned COST_W  = 32;

  // Cost charged for a step of exactly zero.
  localparam int unsigned ZERO_PENALTY = 100000;
  localparam int unsigned PENALTY_W    = $clog2(ZERO_PENALTY + 1);

  // One step cost: wide enough for |a - b| and for the zero-step penalty.
  localparam int unsigned STEP_W = (SAMPLE_BITS + 1 > PENALTY_W) ? SAMPLE_BITS + 1 : PENALTY_W;

  // Product of window index and window length, plus one more length.
  localparam int unsigned SPAN_W = 2 * COUNT_W + 1;

  // Window length after reset.
  localparam logic [COUNT_W-1:0] LENGTH_RESET = COUNT_W'(30);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [COUNT_W-1:0]     count_t;
  typedef logic        [COST_W-1:0]      cost_t;

  // One accepted input beat.
  typedef struct packed {
    sample_t sample;
    logic    last;
  } item_t;

  // One result beat.
  typedef struct packed {
    count_t still_frame;
    count_t windows_seen;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/mwf_item_if.sv
// ----------------------------------------------------------------------------
// mwf_item_if
// Input channel: one coordinate sample per beat with an end-of-track mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwf_item_if;
  import mwf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/mwf_result_if.sv
// ----------------------------------------------------------------------------
// mwf_result_if
// Result channel: start frame of the stillest window and the window count.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwf_result_if;
  import mwf_pkg::*;

  logic   valid;
  logic   ready;
  count_t still_frame;
  count_t windows_seen;

  modport source (output valid, output still_frame, output windows_seen, input ready);
  modport sink   (input valid, input still_frame, input windows_seen, output ready);
endinterface

`default_nettype wire

// File: rtl/mwf_cfg_if.sv
// ----------------------------------------------------------------------------
// mwf_cfg_if
// Configuration write channel carrying the window length.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwf_cfg_if;
  import mwf_pkg::*;

  logic   valid;
  logic   ready;
  count_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/mwf_in_stage.sv
// ----------------------------------------------------------------------------
// mwf_in_stage
// Input register: holds one sample beat until the window core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mwf_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  mwf_item_if.sink           item,
  output mwf_pkg::item_t     held,
  output logic               held_valid,
  input  wire logic          take
);
  import mwf_pkg::*;

  // Refill in the same cycle the core drains the register.
  assign item.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item.ready) begin
      held_valid <= item.valid;
    end
  end

  // Payload, no reset.
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held.sample <= item.sample;
      held.last   <= item.last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mwf_core.sv
// ----------------------------------------------------------------------------
// mwf_core
// Window state update for one beat and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mwf_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mwf_pkg::count_t window_length,
  input  wire mwf_pkg::item_t  held,
  input  wire logic           held_valid,
  output logic                take,
  mwf_result_if.source        result
);
  import mwf_pkg::*;

  // Stream state
  sample_t previous_sample;
  count_t  position_in_window;
  count_t  window_index;
  cost_t   running_cost;
  cost_t   best_cost;
  count_t  best_window;

  sample_t previous_sample_next;
  count_t  position_in_window_next;
  count_t  window_index_next;
  cost_t   running_cost_next;
  cost_t   best_cost_next;
  count_t  best_window_next;

  // Result register
  logic    out_valid;
  result_t out_data;

  logic [2*COUNT_W-1:0]  window_start;
  logic [2*COUNT_W-1:0]  best_start;
  logic [SPAN_W-1:0]     span_end;
  logic                  in_span;
  logic signed [SAMPLE_BITS:0] diff;
  logic [STEP_W-1:0]     mag;
  logic [STEP_W-1:0]     step_cost;
  logic [COST_W:0]       cost_sum;
  cost_t                 cost_now;
  logic                  window_done;
  logic                  take_best;
  result_t               out_data_next;

  // Stall only when a result is due and the result register is still full.
  assign take = held_valid && (!held.last || !out_valid || result.ready);

  // Window fits in the search span when (index + 1) * length <= span.
  assign window_start = COUNT_W'(window_index) * COUNT_W'(window_length);
  assign best_start   = COUNT_W'(best_window) * COUNT_W'(window_length);
  assign span_end     = SPAN_W'(window_start) + SPAN_W'(window_length);
  assign in_span      = (window_length != '0) && (span_end <= SPAN_W'(SEARCH_FRAMES));

  // Step cost: absolute difference, zero step charged the penalty.
  assign diff      = (SAMPLE_BITS+1)'(previous_sample) - (SAMPLE_BITS+1)'(held.sample);
  assign mag       = diff[SAMPLE_BITS] ? STEP_W'(-diff) : STEP_W'(diff);
  assign step_cost = (mag == '0) ? STEP_W'(ZERO_PENALTY) : mag;

  // Saturating accumulate; first frame of a window starts from zero.
  assign cost_sum = (COST_W+1)'(running_cost) + (COST_W+1)'(step_cost);
  always_comb begin
    if (position_in_window == '0) begin
      cost_now = '0;
    end else if (cost_sum[COST_W]) begin
      cost_now = '1;
    end else begin
      cost_now = cost_sum[COST_W-1:0];
    end
  end

  assign window_done = ((COUNT_W+1)'(position_in_window) + (COUNT_W+1)'(1))
                       >= (COUNT_W+1)'(window_length);
  assign take_best   = in_span && window_done
                       && ((window_index == '0) || (cost_now < best_cost));

  // Next stream state
  always_comb begin
    previous_sample_next    = previous_sample;
    position_in_window_next = position_in_window;
    window_index_next       = window_index;
    running_cost_next       = running_cost;
    best_cost_next          = best_cost;
    best_window_next        = best_window;
    if (in_span) begin
      previous_sample_next = held.sample;
      running_cost_next    = cost_now;
      if (window_done) begin
        window_index_next       = window_index + COUNT_W'(1);
        position_in_window_next = '0;
      end else begin
        position_in_window_next = position_in_window + COUNT_W'(1);
      end
      if (take_best) begin
        best_cost_next   = cost_now;
        best_window_next = window_index;
      end
    end
  end

  // Result fields from the updated state
  always_comb begin
    out_data_next.windows_seen = window_index_next;
    if (window_index_next == '0) begin
      out_data_next.still_frame = '0;
    end else if (take_best) begin
      out_data_next.still_frame = window_start[COUNT_W-1:0];
    end else begin
      out_data_next.still_frame = best_start[COUNT_W-1:0];
    end
  end

  // State registers; end of track clears the stream
  always_ff @(posedge clk) begin
    if (rst || (take && held.last)) begin
      previous_sample    <= '0;
      position_in_window <= '0;
      window_index       <= '0;
      running_cost       <= '0;
      best_cost          <= '0;
      best_window        <= '0;
    end else if (take) begin
      previous_sample    <= previous_sample_next;
      position_in_window <= position_in_window_next;
      window_index       <= window_index_next;
      running_cost       <= running_cost_next;
      best_cost          <= best_cost_next;
      best_window        <= best_window_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && held.last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && held.last) begin
      out_data <= out_data_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.still_frame  = out_data.still_frame;
  assign result.windows_seen = out_data.windows_seen;

endmodule

`default_nettype wire

// File: rtl/motionless_window_finder.sv
// ----------------------------------------------------------------------------
// motionless_window_finder
// Finds the stillest fixed-length window at the start of a joint track.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one signed sample per beat; last marks the final frame.
//   result : one beat per track, sent for the beat with last set:
//            still_frame (start frame of the lowest-cost window, 0 when no
//            window completed) and windows_seen.
//   cfg    : writes the window length (frames); always ready. It is to be
//            written only while no beat is in flight; the block itself does
//            not enforce this.
// Throughput: one sample beat per cycle while no last beat waits on a full
//   result register. Each beat passes the input register and one update of
//   the window state (abs difference, saturating 32-bit add, cost compare,
//   8x8 index times length products) into the state and result registers.
// Reset: window length returns to 30, stream state and both registers clear.
// Stall: while a result waits, non-last beats still flow; a second last beat
//   holds in the input register until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module motionless_window_finder (
  input  wire logic    clk,
  input  wire logic    rst,
  mwf_cfg_if.sink      cfg,
  mwf_item_if.sink     item,
  mwf_result_if.source result
);
  import mwf_pkg::*;

  count_t window_length;
  item_t  held;
  logic   held_valid;
  logic   take;

  // Window length register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LENGTH_RESET;
    end else if (cfg.valid) begin
      window_length <= cfg.data;
    end
  end

  mwf_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .held       (held),
    .held_valid (held_valid),
    .take       (take)
  );

  mwf_core u_core (
    .clk           (clk),
    .rst           (rst),
    .window_length (window_length),
    .held          (held),
    .held_valid    (held_valid),
    .take          (take),
    .result        (result)
  );

endmodule

`default_nettype wire

// File: rtl/mwf_checker.sv
// ----------------------------------------------------------------------------
// mwf_checker
// Port-level checks for the motionless window finder.
// ----------------------------------------------------------------------------
`default_nettype none

module mwf_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            item_ready,
  input wire logic            result_valid,
  input wire logic            result_ready,
  input wire mwf_pkg::count_t still_frame,
  input wire mwf_pkg::count_t windows_seen
);
  import mwf_pkg::*;

  // No result right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // With no result pending the input is never back-pressured.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with empty result register");

  // Window count stays within the search span.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (windows_seen <= COUNT_W'(SEARCH_FRAMES)))
    else $error("windows_seen beyond search span");

  // No complete window means start frame zero.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (windows_seen == '0)) |-> (still_frame == '0))
    else $error("still_frame nonzero with no windows");

  // A stalled result beat holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(still_frame) && $stable(windows_seen)))
    else $error("stalled result beat changed");

endmodule

bind motionless_window_finder mwf_checker u_mwf_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .still_frame  (result.still_frame),
  .windows_seen (result.windows_seen)
);

`default_nettype wire

// File: verif/motionless_window_finder_tb.sv
// ----------------------------------------------------------------------------
// motionless_window_finder_tb
// Self-checking bench for the stillest-window search over a joint track.
// Recordings of drifting, held, noisy and rail-to-rail samples are sent
// under several window lengths, with random gaps on the sample and result
// channels. A scoreboard class works out each track's expected start frame
// and window count, and checks every result beat against them in order.
// ----------------------------------------------------------------------------
module motionless_window_finder_tb;
  import mwf_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int TARGET_ITEMS   = 1850;
  localparam int SETTLE_CYCLES  = 8;
  localparam int REPORT_MAX     = 10;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Shapes of a synthetic joint track
  typedef enum int {TRACE_DRIFT, TRACE_HOLD, TRACE_NOISE, TRACE_SWING} trace_kind_t;

  // --------------------------------------------------------------------------
  // Scoreboard: window search state and queued track results
  // --------------------------------------------------------------------------
  class stillness_board_t;
    count_t  win_len;
    sample_t prev_sample;
    count_t  frame_pos;
    count_t  win_idx;
    count_t  best_win;
    cost_t   run_cost;
    cost_t   best_cost;
    result_t track_results[$];
    int      predicted;
    int      failures;

    function new();
      win_len   = LENGTH_RESET;
      predicted = 0;
      failures  = 0;
      clear_track();
    endfunction

    function void clear_track();
      prev_sample = '0;
      frame_pos   = '0;
      win_idx     = '0;
      best_win    = '0;
      run_cost    = '0;
      best_cost   = '0;
    endfunction

    function void set_length(count_t v);
      win_len = v;
    endfunction

    function int pending_count();
      return track_results.size();
    endfunction

    // One accepted sample beat
    function void note_sample(sample_t s, logic is_last);
      count_t                       span_windows;
      logic signed [SAMPLE_BITS:0]  diff;
      logic        [SAMPLE_BITS:0]  mag;
      logic        [STEP_W-1:0]     step;
      logic        [COST_W:0]       sum;
      result_t                      r;
      span_windows = (win_len == '0) ? '0 : count_t'(SEARCH_FRAMES / win_len);
      if (win_idx < span_windows) begin
        if (frame_pos == '0) begin
          run_cost = '0;
        end else begin
          diff = {prev_sample[SAMPLE_BITS-1], prev_sample} - {s[SAMPLE_BITS-1], s};
          mag  = diff[SAMPLE_BITS] ? -diff : diff;
          // a step of exactly zero is charged the penalty
          step = (mag == '0) ? STEP_W'(ZERO_PENALTY) : STEP_W'(mag);
          sum  = {1'b0, run_cost} + (COST_W+1)'(step);
          run_cost = sum[COST_W] ? '1 : sum[COST_W-1:0];
        end
        prev_sample = s;
        // window closes once the position reaches the (possibly new) length
        if ({1'b0, frame_pos} + 9'd1 >= {1'b0, win_len}) begin
          if (win_idx == '0 || run_cost < best_cost) begin
            best_cost = run_cost;
            best_win  = win_idx;
          end
          win_idx   = win_idx + 1'b1;
          frame_pos = '0;
        end else begin
          frame_pos = frame_pos + 1'b1;
        end
      end
      if (is_last) begin
        r.still_frame  = (win_idx == '0) ? '0 : count_t'(best_win * win_len);
        r.windows_seen = win_idx;
        track_results = {track_results, r};
        predicted++;
        clear_track();
      end
    endfunction

    // One accepted result beat against the oldest expected one
    function void compare_result(count_t still_frame, count_t windows_seen);
      result_t want;
      if (track_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("mismatch: unexpected result still_frame=%0d windows_seen=%0d",
                   still_frame, windows_seen);
        return;
      end
      want = track_results.pop_front();
      if (want.still_frame !== still_frame || want.windows_seen !== windows_seen) begin
        failures++;
        if (failures <= REPORT_MAX) begin
          if (want.still_frame !== still_frame)
            $display("mismatch: still_frame expected %0d got %0d",
                     want.still_frame, still_frame);
          if (want.windows_seen !== windows_seen)
            $display("mismatch: windows_seen expected %0d got %0d",
                     want.windows_seen, windows_seen);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count;
  int   items_sent;
  int   result_stall;
  bit   no_idle;

  stillness_board_t board = new();

  mwf_cfg_if    cfg_bus();
  mwf_item_if   item_bus();
  mwf_result_if result_bus();

  motionless_window_finder u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .item   (item_bus),
    .result (result_bus)
  );

  // Clock, period 12
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Result side: check each beat, stall ready at random
  always @(posedge clk) begin : result_sink
    int stall_gap;
    if (rst) begin
      result_bus.ready <= 1'b0;
      result_stall     <= 0;
    end else begin
      if (result_bus.valid && result_bus.ready)
        board.compare_result(result_bus.still_frame, result_bus.windows_seen);
      if (result_stall > 0) begin
        result_bus.ready <= 1'b0;
        result_stall     <= result_stall - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_gap = pick_gap();
        result_bus.ready <= (stall_gap == 0);
        result_stall     <= (stall_gap > 0) ? stall_gap - 1 : 0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Send one sample beat after a random gap
  task automatic send_sample(input sample_t s, input logic is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid  <= 1'b1;
    item_bus.sample <= s;
    item_bus.last   <= is_last;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    board.note_sample(s, is_last);
    items_sent++;
  endtask

  // Write the window length
  task automatic write_length(input count_t v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    board.set_length(v);
  endtask

  // Drain all results, then let the pipeline go quiet
  task automatic settle_block();
    item_bus.valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sample_t next_sample(trace_kind_t kind, sample_t prev);
    case (kind)
      TRACE_DRIFT: return prev + sample_t'(int'($urandom_range(0, 6)) - 3);
      TRACE_HOLD: begin
        if ($urandom_range(0, 9) == 0)
          return prev + sample_t'(int'($urandom_range(0, 40)) - 20);
        return prev;
      end
      TRACE_NOISE: return sample_t'($urandom);
      default:     return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
    endcase
  endfunction

  // One recording; close = 0 leaves it open across a length change
  task automatic play_track(input int frames, input bit close);
    trace_kind_t kind;
    sample_t     s;
    kind = trace_kind_t'($urandom_range(0, 3));
    s    = sample_t'($urandom);
    for (int i = 0; i < frames; i++) begin
      if ($urandom_range(0, 19) == 0)
        kind = trace_kind_t'($urandom_range(0, 3));
      s = next_sample(kind, s);
      send_sample(s, close && (i == frames - 1));
    end
  endtask

  function automatic int pick_track_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 30);
    if (r < 90) return $urandom_range(31, 160);
    return $urandom_range(150, 220);
  endfunction

  function automatic count_t pick_length();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return '0;
      1:       return count_t'(1);
      2:       return count_t'(SEARCH_FRAMES);
      3:       return count_t'($urandom_range(SEARCH_FRAMES + 1, 255));
      4:       return '1;
      5, 6, 7, 8, 9:      return count_t'($urandom_range(2, 10));
      10, 11, 12, 13, 14: return count_t'($urandom_range(11, 50));
      default: return count_t'($urandom_range(51, SEARCH_FRAMES - 1));
    endcase
  endfunction

  // Stimulus
  initial begin
    count_t wl;
    int     tracks;
    rst              = 1'b1;
    items_sent       = 0;
    no_idle          = 1'b0;
    item_bus.valid   <= 1'b0;
    item_bus.sample  <= '0;
    item_bus.last    <= 1'b0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.data     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset length, track shorter than one window
    send_sample(sample_t'(100), 1'b0);
    send_sample(sample_t'(-7), 1'b0);
    send_sample(sample_t'(-7), 1'b1);
    settle_block();

    // Full-scale steps, zero-step penalty, later window strictly cheaper
    write_length(count_t'(2));
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(sample_t'(0), 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(5), 1'b1);
    settle_block();

    // One-frame windows cost nothing, ties keep the first
    write_length(count_t'(1));
    send_sample(sample_t'(3), 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    settle_block();

    // Zero length: nothing completes
    write_length('0);
    send_sample(sample_t'(12), 1'b0);
    send_sample(sample_t'(-12), 1'b1);
    settle_block();

    // Window longer than the search span
    write_length('1);
    send_sample(sample_t'(1), 1'b1);
    settle_block();

    // Length change in the middle of a recording
    write_length(count_t'(2));
    send_sample(sample_t'(10), 1'b0);
    send_sample(sample_t'(20), 1'b0);
    send_sample(sample_t'(25), 1'b0);
    settle_block();
    write_length(count_t'(3));
    send_sample(sample_t'(26), 1'b0);
    send_sample(sample_t'(40), 1'b1);
    settle_block();

    // Random phases, one window length each
    while (items_sent < TARGET_ITEMS) begin
      wl = pick_length();
      write_length(wl);
      no_idle = ($urandom_range(0, 4) == 0);
      if (wl == '0 || wl > SEARCH_FRAMES)
        tracks = $urandom_range(1, 2);
      else
        tracks = $urandom_range(2, 6);
      for (int t = 0; t < tracks; t++)
        play_track(pick_track_len(), 1'b1);
      if ($urandom_range(0, 4) == 0)
        play_track($urandom_range(1, 60), 1'b0);
      settle_block();
    end

    no_idle = 1'b0;
    settle_block();
    if (board.failures == 0 && board.pending_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
